// ===== src/dsp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dsp_pkg
// Shared types, codes and constants of the distance sample policy core.
// ============================================================================
package dsp_pkg;

  // Field widths
  localparam int DIST_W    = 16;
  localparam int TIMER_W   = 16;
  localparam int OP_W      = 2;
  localparam int CFG_NUM   = 8;
  localparam int ADDR_W    = 5;
  localparam int APB_W     = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Operation codes carried in tuser of the input stream
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE   = 2'd0,
    OP_TICK     = 2'd1,
    OP_ANNOUNCE = 2'd2,
    OP_EXIT     = 2'd3
  } op_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_MIN_DIST  = 3'd0,
    REG_MAX_DIST  = 3'd1,
    REG_FAST_DELTA = 3'd2,
    REG_FAST_DUR  = 3'd3,
    REG_FRESH_WIN = 3'd4,
    REG_COOLDOWN  = 3'd5,
    REG_FAST_INTV = 3'd6,
    REG_BASE_INTV = 3'd7
  } reg_idx_t;

  // Register reset values
  localparam logic [15:0] RST_MIN_DIST   = 16'd0;
  localparam logic [15:0] RST_MAX_DIST   = 16'd4000;
  localparam logic [15:0] RST_FAST_DELTA = 16'd100;
  localparam logic [15:0] RST_FAST_DUR   = 16'd5000;
  localparam logic [15:0] RST_FRESH_WIN  = 16'd1000;
  localparam logic [15:0] RST_COOLDOWN   = 16'd10000;
  localparam logic [15:0] RST_FAST_INTV  = 16'd100;
  localparam logic [15:0] RST_BASE_INTV  = 16'd1000;

  // Configuration register file
  typedef struct packed {
    logic [DIST_W-1:0]  min_distance_mm;
    logic [DIST_W-1:0]  max_distance_mm;
    logic [DIST_W-1:0]  fast_delta_mm;
    logic [TIMER_W-1:0] fast_duration_ms;
    logic [TIMER_W-1:0] fresh_window_ms;
    logic [TIMER_W-1:0] cooldown_ms;
    logic [TIMER_W-1:0] fast_interval_ms;
    logic [TIMER_W-1:0] base_interval_ms;
  } cfg_t;

  // Result item
  typedef struct packed {
    logic               may_announce;
    logic [TIMER_W-1:0] poll_interval_ms;
    logic               fast_active;
    logic               distance_fresh;
    logic               have_distance;
    logic [DIST_W-1:0]  latest_mm;
    logic               accepted;
  } result_t;

  // A zero duration loads as one so the flag clears on the next tick
  function automatic logic [TIMER_W-1:0] load_value(input logic [TIMER_W-1:0] d);
    load_value = (d == '0) ? TIMER_W'(1) : d;
  endfunction

endpackage

// ===== src/distance_sample_policy_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// distance_sample_policy_core
// Qualifies distance samples, keeps fast polling mode, freshness and the
// announcement cooldown, and reports the polling interval for every item.
// ============================================================================
// Usage:
//   Input stream (s_*): one item per transfer. s_tuser carries the operation
//   (sample, millisecond tick, announce request, exit fast mode); s_tdata
//   carries the raw distance and its finite flag.
//   Output stream (m_*): exactly one result per input item, in order,
//   describing the state after that item.
//   APB port: eight 16-bit registers at byte addresses 0 to 28; write them
//   only while the block is idle. pready is tied high.
// Latency: the result of an item is in the output register the cycle after
//   its transfer. Throughput: one item per cycle while the output is not
//   stalled, set by the single output register that follows the state update.
// Stall: while the output register holds a result that is not taken,
//   s_tready follows m_tready, so a new item enters in the same cycle as the
//   waiting result leaves.
// Reset: synchronous; clears all flags and timers, the output valid, and
//   loads the registers with their default values.
// ============================================================================
module distance_sample_policy_core import dsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // [15:0] distance_mm, [16] distance_finite
  input  logic [OP_W-1:0]       s_tuser,  // [1:0] operation
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] accepted, [16:1] latest_mm, [17] have_distance, [18] distance_fresh,
  // [19] fast_active, [35:20] poll_interval_ms, [36] may_announce
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  cfg_t cfg;

  logic [DIST_W-1:0]  last_distance, last_distance_next;
  logic               have_sample, have_sample_next;
  logic               fresh_flag, fresh_flag_next;
  logic               fast_flag, fast_flag_next;
  logic               cooldown_flag, cooldown_flag_next;
  logic [TIMER_W-1:0] fast_timer, fast_timer_next;
  logic [TIMER_W-1:0] fresh_timer, fresh_timer_next;
  logic [TIMER_W-1:0] cooldown_timer, cooldown_timer_next;

  result_t            res_next;
  result_t            res;
  logic               out_valid;

  logic               in_xfer;
  logic               cfg_wr;
  reg_idx_t           reg_idx;
  op_t                op;
  logic [DIST_W-1:0]  sample_mm;
  logic               finite;
  logic               in_window;
  logic [DIST_W-1:0]  delta;
  logic               accepted;
  logic               granted;

  // Handshake
  assign s_tready = !out_valid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'(res);

  // Register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MIN_DIST:   prdata = APB_W'(cfg.min_distance_mm);
      REG_MAX_DIST:   prdata = APB_W'(cfg.max_distance_mm);
      REG_FAST_DELTA: prdata = APB_W'(cfg.fast_delta_mm);
      REG_FAST_DUR:   prdata = APB_W'(cfg.fast_duration_ms);
      REG_FRESH_WIN:  prdata = APB_W'(cfg.fresh_window_ms);
      REG_COOLDOWN:   prdata = APB_W'(cfg.cooldown_ms);
      REG_FAST_INTV:  prdata = APB_W'(cfg.fast_interval_ms);
      REG_BASE_INTV:  prdata = APB_W'(cfg.base_interval_ms);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_distance_mm  <= RST_MIN_DIST;
      cfg.max_distance_mm  <= RST_MAX_DIST;
      cfg.fast_delta_mm    <= RST_FAST_DELTA;
      cfg.fast_duration_ms <= RST_FAST_DUR;
      cfg.fresh_window_ms  <= RST_FRESH_WIN;
      cfg.cooldown_ms      <= RST_COOLDOWN;
      cfg.fast_interval_ms <= RST_FAST_INTV;
      cfg.base_interval_ms <= RST_BASE_INTV;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_DIST:   cfg.min_distance_mm  <= pwdata[DIST_W-1:0];
        REG_MAX_DIST:   cfg.max_distance_mm  <= pwdata[DIST_W-1:0];
        REG_FAST_DELTA: cfg.fast_delta_mm    <= pwdata[DIST_W-1:0];
        REG_FAST_DUR:   cfg.fast_duration_ms <= pwdata[TIMER_W-1:0];
        REG_FRESH_WIN:  cfg.fresh_window_ms  <= pwdata[TIMER_W-1:0];
        REG_COOLDOWN:   cfg.cooldown_ms      <= pwdata[TIMER_W-1:0];
        REG_FAST_INTV:  cfg.fast_interval_ms <= pwdata[TIMER_W-1:0];
        REG_BASE_INTV:  cfg.base_interval_ms <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input item and qualify the sample
  assign op        = op_t'(s_tuser);
  assign sample_mm = s_tdata[DIST_W-1:0];
  assign finite    = s_tdata[DIST_W];
  assign in_window = finite && (sample_mm >= cfg.min_distance_mm)
                            && (sample_mm <= cfg.max_distance_mm);
  assign delta     = (sample_mm >= last_distance) ? (sample_mm - last_distance)
                                                  : (last_distance - sample_mm);

  // Work out the state after this item
  always_comb begin
    last_distance_next  = last_distance;
    have_sample_next    = have_sample;
    fresh_flag_next     = fresh_flag;
    fast_flag_next      = fast_flag;
    cooldown_flag_next  = cooldown_flag;
    fast_timer_next     = fast_timer;
    fresh_timer_next    = fresh_timer;
    cooldown_timer_next = cooldown_timer;
    accepted            = 1'b0;
    granted             = 1'b0;
    unique case (op)
      OP_SAMPLE: begin
        if (in_window) begin
          if (have_sample && (delta >= cfg.fast_delta_mm)) begin
            fast_flag_next  = 1'b1;
            fast_timer_next = load_value(cfg.fast_duration_ms);
          end
          last_distance_next = sample_mm;
          have_sample_next   = 1'b1;
          fresh_flag_next    = 1'b1;
          fresh_timer_next   = load_value(cfg.fresh_window_ms);
          accepted           = 1'b1;
        end
      end
      OP_TICK: begin
        // Count running timers down; drop the flag as a timer expires
        if (fast_timer != '0) begin
          fast_timer_next = fast_timer - TIMER_W'(1);
          if (fast_timer == TIMER_W'(1)) fast_flag_next = 1'b0;
        end
        if (fresh_timer != '0) begin
          fresh_timer_next = fresh_timer - TIMER_W'(1);
          if (fresh_timer == TIMER_W'(1)) fresh_flag_next = 1'b0;
        end
        if (cooldown_timer != '0) begin
          cooldown_timer_next = cooldown_timer - TIMER_W'(1);
          if (cooldown_timer == TIMER_W'(1)) cooldown_flag_next = 1'b0;
        end
      end
      OP_ANNOUNCE: begin
        if (!cooldown_flag) begin
          cooldown_flag_next  = 1'b1;
          cooldown_timer_next = load_value(cfg.cooldown_ms);
          granted             = 1'b1;
        end
      end
      OP_EXIT: begin
        fast_flag_next  = 1'b0;
        fast_timer_next = '0;
      end
      default: ;
    endcase

    res_next.accepted         = accepted;
    res_next.latest_mm        = last_distance_next;
    res_next.have_distance    = have_sample_next;
    res_next.distance_fresh   = fresh_flag_next;
    res_next.fast_active      = fast_flag_next;
    res_next.poll_interval_ms = fast_flag_next ? cfg.fast_interval_ms
                                               : cfg.base_interval_ms;
    res_next.may_announce     = granted;
  end

  // Advance state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance  <= '0;
      have_sample    <= 1'b0;
      fresh_flag     <= 1'b0;
      fast_flag      <= 1'b0;
      cooldown_flag  <= 1'b0;
      fast_timer     <= '0;
      fresh_timer    <= '0;
      cooldown_timer <= '0;
    end else if (in_xfer) begin
      last_distance  <= last_distance_next;
      have_sample    <= have_sample_next;
      fresh_flag     <= fresh_flag_next;
      fast_flag      <= fast_flag_next;
      cooldown_flag  <= cooldown_flag_next;
      fast_timer     <= fast_timer_next;
      fresh_timer    <= fresh_timer_next;
      cooldown_timer <= cooldown_timer_next;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res <= res_next;
    end
  end

  // Each flag runs exactly while its timer runs
  a_fast_timer: assert property (@(posedge clk) disable iff (rst)
    fast_flag == (fast_timer != '0))
    else $error("fast flag and fast timer disagree");

  a_fresh_timer: assert property (@(posedge clk) disable iff (rst)
    fresh_flag == (fresh_timer != '0))
    else $error("fresh flag and fresh timer disagree");

  a_cooldown_timer: assert property (@(posedge clk) disable iff (rst)
    cooldown_flag == (cooldown_timer != '0))
    else $error("cooldown flag and cooldown timer disagree");

  // A result never both accepts a sample and grants an announcement
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.accepted && res.may_announce))
    else $error("result marks both a sample and an announcement");

endmodule
